// ===== rtl/vwbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vwbs_pkg
// Shared constants and types for the variable width bit stack.
// ----------------------------------------------------------------------------
package vwbs_pkg;

    // storage geometry
    localparam int STACK_WORDS = 32;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_WORDS);
    localparam int CNT_W       = $clog2(STACK_WORDS + 1);

    // transaction field widths
    localparam int REQ_W = 1;
    localparam int WID_W = 5;
    localparam int VAL_W = 31;
    localparam int AMT_W = 6;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH = 1'b0;
    localparam logic [REQ_W-1:0] REQ_POP  = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

endpackage

// ===== rtl/vwbs_req_if.sv =====
// ----------------------------------------------------------------------------
// vwbs_req_if
// Request channel: push or pop of a number of bits.
// ----------------------------------------------------------------------------
interface vwbs_req_if
    import vwbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [WID_W-1:0] width;
    logic [VAL_W-1:0] push_value;

    modport source (output valid, req_type, width, push_value, input ready);
    modport sink   (input valid, req_type, width, push_value, output ready);
endinterface

// ===== rtl/vwbs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vwbs_rsp_if
// Response channel: bits taken from the stack by a pop.
// ----------------------------------------------------------------------------
interface vwbs_rsp_if
    import vwbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] pop_value;

    modport source (output valid, pop_value, input ready);
    modport sink   (input valid, pop_value, output ready);
endinterface

// ===== rtl/variable_width_bit_stack.sv =====
// ----------------------------------------------------------------------------
// variable_width_bit_stack
// Long bit register used as a LIFO of bits, kept in a word memory and
// shifted one word per cycle through a single funnel shifter.
// ----------------------------------------------------------------------------
// Push or pop of nonzero width: the block is busy for a sweep over all STACK_WORDS
//   words, read and written word by word in a memory with one read and one write port.
// Pop result is valid once the sweep has ended; a zero-width pop answers in the
//   cycle after acceptance; a zero-width push leaves the stack and the block idle.
// One transaction at a time: a new request is taken once the sweep and any result are gone.
// Synchronous active-low reset clears the sequencer and all word valid bits,
//   so the whole stack reads as zeros after reset.
// ----------------------------------------------------------------------------
module variable_width_bit_stack
    import vwbs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    vwbs_req_if.sink     i_req,
    vwbs_rsp_if.source   o_rsp
);

    // storage
    logic [WORD_W-1:0]      r_mem [STACK_WORDS];
    logic [STACK_WORDS-1:0] r_valid;

    // sequencer and request registers
    t_state            r_state, n_state;
    logic [REQ_W-1:0]  r_req;
    logic [WID_W-1:0]  r_width;
    logic [VAL_W-1:0]  r_push_val;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_data_ok;
    logic              r_first, n_first;
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_prev, n_prev;
    logic [VAL_W-1:0]  r_out, n_out;

    logic              accept;
    logic              rd_issue;
    logic              is_push;
    logic [VAL_W-1:0]  width_mask;
    logic [2*WORD_W-1:0] sh_in;
    logic [2*WORD_W-1:0] sh_out;
    logic [AMT_W-1:0]  sh_amt;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    assign accept   = i_req.valid && i_req.ready;
    assign rd_issue = (r_state == S_RUN) && (r_left != '0);
    assign is_push  = (r_req == REQ_PUSH);
    assign wr_en    = (r_state == S_RUN) && r_data_ok;

    // low mask of the current width
    assign width_mask = ~({VAL_W{1'b1}} << r_width);

    // shared funnel shifter: push moves the word up, pop moves it down
    always_comb begin
        if (is_push) begin
            sh_in  = {r_rd_data, r_prev};
            sh_amt = AMT_W'(WORD_W) - AMT_W'(r_width);
        end else begin
            sh_in  = {r_prev, r_rd_data};
            sh_amt = AMT_W'(r_width);
        end
        sh_out = sh_in >> sh_amt;
    end

    // bottom word of a push takes the new bits
    always_comb begin
        wr_data = sh_out[WORD_W-1:0];
        if (is_push && r_first) begin
            wr_data = wr_data | WORD_W'(r_push_val & width_mask);
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_rd_addr = r_rd_addr;
        n_left    = r_left;
        n_first   = r_first;
        n_prev    = r_prev;
        n_out     = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_first = 1'b1;
                    n_prev  = '0;
                    n_left  = CNT_W'(STACK_WORDS);
                    if (i_req.req_type == REQ_POP) begin
                        n_rd_addr = '0;
                    end else begin
                        n_rd_addr = ADDR_W'(STACK_WORDS - 1);
                    end
                    if (i_req.width != '0) begin
                        n_state = S_RUN;
                    end else if (i_req.req_type == REQ_POP) begin
                        n_out   = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_RUN: begin
                if (rd_issue) begin
                    n_left = r_left - CNT_W'(1);
                    if (is_push) begin
                        n_rd_addr = r_rd_addr - ADDR_W'(1);
                    end else begin
                        n_rd_addr = r_rd_addr + ADDR_W'(1);
                    end
                end
                if (r_data_ok) begin
                    n_first = 1'b0;
                    n_prev  = r_rd_data;
                    if (r_left == '0) begin
                        if (is_push) begin
                            n_state = S_IDLE;
                        end else begin
                            n_out   = r_rd_data[VAL_W-1:0] & width_mask;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_left    <= '0;
            r_data_ok <= 1'b0;
            r_first   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_data_ok <= rd_issue;
            r_first   <= n_first;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_req.req_type;
            r_width    <= i_req.width;
            r_push_val <= i_req.push_value;
        end
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= r_rd_addr;
        r_prev    <= n_prev;
        r_out     <= n_out;
    end

    // word valid bits, a word never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_wr_addr] <= 1'b1;
        end
    end

    // storage memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_addr] <= wr_data;
        end
        if (rd_issue) begin
            r_rd_data <= r_valid[r_rd_addr] ? r_mem[r_rd_addr] : '0;
        end
    end

    // channel outputs
    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = (r_state == S_OUT);
    assign o_rsp.pop_value = r_out;

    // no request is taken while a result waits
    a_ready_not_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request taken while result pending");

    // a nonzero-width transaction makes the block busy
    a_busy_after_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.width != '0)) |=> (r_state == S_RUN) && !i_req.ready)
        else $error("sweep did not start");

    // a result appears only after a sweep or a zero-width pop
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_state == S_RUN) ||
                                ($past(accept) && $past(i_req.width == '0))))
        else $error("result without a pop");

    // memory writes only follow a read of the same sweep
    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> $past(rd_issue))
        else $error("write without read data");

endmodule
